// File: hw/rtl/mbd_pkg.sv
// mbd_pkg: shared types, constants and channel arithmetic for the mipmap box downsampler
// no dependencies; imported by every module of the block
package mbd_pkg;

  localparam int MAX_LOG2_SIZE_DEF = 12;
  // result queue per level; half the cascade length keeps the merge from starving
  localparam int QUEUE_DEPTH       = MAX_LOG2_SIZE_DEF / 2;

  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W    = 32;
  localparam int CH_W     = 8;
  localparam int SUM_CH_W = 9;
  localparam int NUM_CH   = 4;
  localparam int SUM_W    = SUM_CH_W * NUM_CH;
  localparam int LEVEL_W  = 4;
  localparam int COORD_W  = 11;

  localparam int OUT_BITS = PIX_W + LEVEL_W + 2 * COORD_W;
  localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_HEIGHT = 1'b1;

  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LEVEL_W-1:0] level;
    logic [PIX_W-1:0]   mip_pixel;
  } result_t;

  // per channel horizontal sum of two pixels, 9 bits per channel
  function automatic logic [SUM_W-1:0] add_pair(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] r;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      r[ch*SUM_CH_W +: SUM_CH_W] = {1'b0, a[ch*CH_W +: CH_W]} + {1'b0, b[ch*CH_W +: CH_W]};
    end
    return r;
  endfunction

  // floored mean of a 2x2 block from its two pair sums
  function automatic logic [PIX_W-1:0] average_block(input logic [SUM_W-1:0] top,
                                                     input logic [SUM_W-1:0] bottom);
    logic [PIX_W-1:0]    r;
    logic [SUM_CH_W:0]   s;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s = {1'b0, top[ch*SUM_CH_W +: SUM_CH_W]} + {1'b0, bottom[ch*SUM_CH_W +: SUM_CH_W]};
      r[ch*CH_W +: CH_W] = s[SUM_CH_W:2];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mbd_fifo.sv
// mbd_fifo: small result queue behind one level cell
// depends on mbd_pkg (result_t)
module mbd_fifo #(
  parameter int DEPTH = mbd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mbd_pkg::result_t push_data,
  input  logic            pop,
  output logic            head_valid,
  output mbd_pkg::result_t head,
  output logic            full
);
  import mbd_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CNTW-1:0] cnt;

  assign head_valid = (cnt != '0);
  assign full       = (cnt == FULL_CNT);
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == LAST_PTR) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == LAST_PTR) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule

// File: hw/rtl/mbd_cell.sv
// mbd_cell: one mip level of the cascade, with counters, held left pixel and line store
// depends on mbd_pkg and mbd_fifo
module mbd_cell #(
  parameter int MAX_LOG2_SIZE = mbd_pkg::MAX_LOG2_SIZE_DEF,
  parameter int STAGE         = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       clear,
  input  logic [mbd_pkg::CFG_W-1:0]  lw,
  input  logic [mbd_pkg::CFG_W-1:0]  lh,
  input  logic                       in_valid,
  input  logic [mbd_pkg::PIX_W-1:0]  in_pixel,
  input  logic                       next_take,
  output logic                       take,
  output logic                       out_valid,
  output logic [mbd_pkg::PIX_W-1:0]  out_pixel,
  input  logic                       pop,
  output logic                       head_valid,
  output mbd_pkg::result_t           head,
  output logic                       full
);
  import mbd_pkg::*;

  localparam int CW    = MAX_LOG2_SIZE - STAGE;
  localparam int AW    = (CW > 1) ? CW - 1 : 1;
  localparam int DEPTH = 1 << AW;
  // while the merge waits on a deep level, later beats keep adding level-1 results;
  // the queue must not fill before that deep result is pushed
  localparam int Q_DEPTH = (MAX_LOG2_SIZE > 4) ? MAX_LOG2_SIZE / 2 : 2;
  localparam logic [CFG_W-1:0]   STAGE_C = CFG_W'(STAGE);
  localparam logic [CFG_W-1:0]   CW_C    = CFG_W'(CW);
  localparam logic [LEVEL_W-1:0] LEVEL_C = LEVEL_W'(STAGE + 1);

  logic [CW-1:0]      col;
  logic [CW-1:0]      row;
  logic [CW-1:0]      col_max;
  logic [CW-1:0]      row_max;
  logic               active;
  logic               load;
  logic [AW-1:0]      addr;
  logic [PIX_W-1:0]   left;
  logic [SUM_W-1:0]   pair;
  logic [SUM_W-1:0]   pair_q;
  logic [SUM_W-1:0]   top_q;
  logic [SUM_W-1:0]   store [DEPTH];
  logic [COORD_W-1:0] ocol;
  logic [COORD_W-1:0] orow;
  result_t            res;

  assign active  = (lw > STAGE_C) && (lh > STAGE_C);
  // level size minus one as an all-ones mask
  assign col_max = {CW{1'b1}} >> (CW_C - (lw - STAGE_C));
  assign row_max = {CW{1'b1}} >> (CW_C - (lh - STAGE_C));
  assign load    = adv && in_valid && active;
  assign take    = load && col[0] && row[0];
  assign addr    = AW'(col >> 1);
  assign pair    = add_pair(left, in_pixel);

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else if (clear) begin
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= take;
      if (load) begin
        if (col == col_max) begin
          col <= '0;
          row <= (row == row_max) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  // payload: left pixel, line store and the block being finished
  always_ff @(posedge clk) begin
    if (load) begin
      if (!col[0]) begin
        left <= in_pixel;
      end
      if (col[0] && !row[0]) begin
        store[addr] <= pair;
      end
      if (col[0] && row[0]) begin
        top_q  <= store[addr];
        pair_q <= pair;
        ocol   <= COORD_W'(col >> 1);
        orow   <= COORD_W'(row >> 1);
      end
    end
  end

  assign out_pixel = average_block(top_q, pair_q);

  always_comb begin
    res.mip_pixel = out_pixel;
    res.level     = LEVEL_C;
    res.col       = ocol;
    res.row       = orow;
    res.last      = !next_take;
  end

  mbd_fifo #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && out_valid),
    .push_data (res),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head),
    .full      (full)
  );

endmodule

// File: hw/rtl/mipmap_box_downsample.sv
// mipmap_box_downsample: streaming 2x2 box filter mipmap generator for RGBA8 images
// depends on mbd_pkg and mbd_cell
// throughput: one input beat per cycle while s_tready is high, one result beat per cycle while
// m_tready is high; s_tready drops while any level queue is full, since each level cell hands
// one beat per cycle down the chain; reset clears both exponents to zero (no levels: input beats
// give no result), all counters and queues; the line stores are not cleared and are always written before they are read
module mipmap_box_downsample #(
  parameter int MAX_LOG2_SIZE = mbd_pkg::MAX_LOG2_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [mbd_pkg::CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mbd_pkg::PIX_W-1:0]     s_tdata,   // pixel
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mbd_pkg::TDATA_W-1:0]   m_tdata,   // mip_pixel, level, col, row, zero pad
  output logic                          m_tlast
);
  import mbd_pkg::*;

  localparam int PTR_W = (MAX_LOG2_SIZE > 1) ? $clog2(MAX_LOG2_SIZE) : 1;
  localparam logic [CFG_W-1:0] MAX_C = CFG_W'(MAX_LOG2_SIZE);

  // configuration
  logic [CFG_W-1:0] log2_width;
  logic [CFG_W-1:0] log2_height;
  logic [CFG_W-1:0] lw_c;
  logic [CFG_W-1:0] lh_c;

  // cascade links
  logic [MAX_LOG2_SIZE-1:0] cell_valid;
  logic [MAX_LOG2_SIZE-1:0] cell_take;
  logic [PIX_W-1:0]         cell_pix [MAX_LOG2_SIZE];
  logic [MAX_LOG2_SIZE-1:0] head_valid;
  logic [MAX_LOG2_SIZE-1:0] full;
  logic [MAX_LOG2_SIZE-1:0] pop;
  result_t                  heads [MAX_LOG2_SIZE];
  logic                     adv;

  // result merge
  logic [PTR_W-1:0] ptr;
  result_t          sel;
  logic             sel_valid;
  logic             pop_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_width  <= '0;
      log2_height <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LOG2_WIDTH:  log2_width  <= cfg_data;
        REG_LOG2_HEIGHT: log2_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // exponents above the cascade length saturate
  assign lw_c = (log2_width  > MAX_C) ? MAX_C : log2_width;
  assign lh_c = (log2_height > MAX_C) ? MAX_C : log2_height;

  // the whole chain steps together; each step adds at most one beat to each queue
  assign adv      = ~|full;
  assign s_tready = adv;

  for (genvar s = 0; s < MAX_LOG2_SIZE; s++) begin : g_cell
    logic             in_valid;
    logic [PIX_W-1:0] in_pixel;
    logic             next_take;

    if (s == 0) begin : g_head
      assign in_valid = s_tvalid;
      assign in_pixel = s_tdata;
    end else begin : g_link
      assign in_valid = cell_valid[s-1];
      assign in_pixel = cell_pix[s-1];
    end

    // a result is the last of its beat unless the next level finishes a block with it
    if (s == MAX_LOG2_SIZE - 1) begin : g_tail
      assign next_take = 1'b0;
    end else begin : g_mid
      assign next_take = cell_take[s+1];
    end

    mbd_cell #(
      .MAX_LOG2_SIZE(MAX_LOG2_SIZE),
      .STAGE        (s)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .clear     (cfg_we),
      .lw        (lw_c),
      .lh        (lh_c),
      .in_valid  (in_valid),
      .in_pixel  (in_pixel),
      .next_take (next_take),
      .take      (cell_take[s]),
      .out_valid (cell_valid[s]),
      .out_pixel (cell_pix[s]),
      .pop       (pop[s]),
      .head_valid(head_valid[s]),
      .head      (heads[s]),
      .full      (full[s])
    );
  end

  // merge walks the queues level by level; a beat's results sit at the heads in order
  assign sel       = heads[ptr];
  assign sel_valid = head_valid[ptr];
  assign pop_en    = sel_valid && (!m_tvalid || m_tready);
  assign pop       = pop_en ? (MAX_LOG2_SIZE'(1) << ptr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop_en) begin
        ptr <= sel.last ? '0 : ptr + 1'b1;
      end
      if (!m_tvalid || m_tready) begin
        m_tvalid <= sel_valid;
      end
    end
  end

  // output register, payload only
  always_ff @(posedge clk) begin
    if (pop_en) begin
      m_tdata <= TDATA_W'({sel.row, sel.col, sel.level, sel.mip_pixel});
      m_tlast <= sel.last;
    end
  end

endmodule

// File: hw/rtl/mbd_checker.sv
// mbd_checker: port-level checks on the result stream of the mipmap downsampler
// depends on mbd_pkg; bound to mipmap_box_downsample below
module mbd_checker #(
  parameter int MAX_LOG2_SIZE = mbd_pkg::MAX_LOG2_SIZE_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [mbd_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tlast
);
  import mbd_pkg::*;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(MAX_LOG2_SIZE);

  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] exp_level;

  assign level = m_tdata[PIX_W +: LEVEL_W];

  // levels of one input beat come out 1, 2, ... up to the last
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_level <= LEVEL_W'(1);
    end else if (m_tvalid && m_tready) begin
      exp_level <= m_tlast ? LEVEL_W'(1) : level + 1'b1;
    end
  end

  a_level_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> level == exp_level)
    else $error("result level out of sequence");

  a_top_level_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && level == MAX_LEVEL |-> m_tlast)
    else $error("deepest level beat without tlast");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

endmodule

bind mipmap_box_downsample mbd_checker #(
  .MAX_LOG2_SIZE(MAX_LOG2_SIZE)
) u_mbd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

// File: test/mipmap_box_downsample_tb.sv
// mipmap_box_downsample_tb: self-checking testbench for the streaming 2x2 box filter mipmap block
// depends on mbd_pkg and the mipmap_box_downsample rtl; holds its own level cascade predictor
// streams corner, random and saturated-size images with random gaps on both sides
module mipmap_box_downsample_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  localparam int MAX_LOG2      = MAX_LOG2_SIZE_DEF;
  localparam int LINE_DEPTH    = 1 << MAX_LOG2;
  localparam int SETTLE_CYCLES = 40;    // well past the deepest level latency
  localparam int STALL_LIMIT   = 2000;  // cycles without any beat before giving up
  localparam int MAX_REPORTS   = 40;

  // result beat layout on m_tdata
  localparam int LEVEL_LSB = PIX_W;
  localparam int COL_LSB   = LEVEL_LSB + LEVEL_W;
  localparam int ROW_LSB   = COL_LSB + COORD_W;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [PIX_W-1:0]     s_tdata = '0;     // pixel
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;          // mip_pixel, level, col, row, zero pad
  logic                 m_tlast;

  mipmap_box_downsample DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: exponents as written, a shared line store, per-level held pixels and counters
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] log2_w_reg, log2_h_reg;
  logic [SUM_W-1:0] pair_line  [0:LINE_DEPTH-1];
  logic [PIX_W-1:0] held_left  [0:MAX_LOG2-1];
  logic [11:0]      stage_col  [0:MAX_LOG2];
  logic [11:0]      stage_row  [0:MAX_LOG2];

  result_t pending_mips[$];   // expected result beats, oldest first

  // pacing: calm phases run with no gaps on that side
  bit tx_calm, rx_calm;
  int rx_wait;

  int mismatches;
  int pixels_sent, mips_checked, size_settings, deepest_level;
  int stall_cycles;

  // per channel sum of two horizontally adjacent pixels, 9 bits a channel
  function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] r;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++)
      r[ch*SUM_CH_W +: SUM_CH_W] = {1'b0, a[ch*CH_W +: CH_W]} + {1'b0, b[ch*CH_W +: CH_W]};
    return r;
  endfunction

  // floored mean of four pixels given as top and bottom pair sums
  function automatic logic [PIX_W-1:0] box_mean(input logic [SUM_W-1:0] top,
                                                input logic [SUM_W-1:0] bottom);
    logic [PIX_W-1:0] r;
    int unsigned      total;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total = 32'(top[ch*SUM_CH_W +: SUM_CH_W]) + 32'(bottom[ch*SUM_CH_W +: SUM_CH_W]);
      r[ch*CH_W +: CH_W] = CH_W'(total / 4);
    end
    return r;
  endfunction

  // channels lean towards 00 and ff so carries and floors get exercised
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(0, 5))
        0: p[ch*CH_W +: CH_W] = 8'h00;
        1: p[ch*CH_W +: CH_W] = 8'hff;
        default: p[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  // runs one accepted base pixel down the level cascade, queueing every mip beat it completes
  task automatic predict_mips(input logic [PIX_W-1:0] pix);
    int unsigned      lw, lh, levels, ws, hs, c, r, addr, oc, orow;
    logic [PIX_W-1:0] cur, avg;
    logic [SUM_W-1:0] pair;
    bit               done;
    result_t          fresh[$];
    result_t          res;
    lw = (log2_w_reg > MAX_LOG2) ? MAX_LOG2 : log2_w_reg;
    lh = (log2_h_reg > MAX_LOG2) ? MAX_LOG2 : log2_h_reg;
    levels = (lw < lh) ? lw : lh;
    cur = pix;
    for (int s = 0; s < levels; s++) begin
      ws = 1 << (lw - s);
      hs = 1 << (lh - s);
      c = stage_col[s];
      r = stage_row[s];
      // each level owns a slice of the line store, packed after the wider ones
      addr = ((1 << lw) - ws + (c >> 1)) % LINE_DEPTH;
      done = 1'b0;
      if ((c & 1) == 0) begin
        held_left[s] = cur;
      end else begin
        pair = pair_sum(held_left[s], cur);
        if ((r & 1) == 0) begin
          pair_line[addr] = pair;
        end else begin
          avg = box_mean(pair_line[addr], pair);
          done = 1'b1;
        end
      end
      c++;
      if (c >= ws) begin
        c = 0;
        r++;
        if (r >= hs) r = 0;
      end
      stage_col[s] = 12'(c);
      stage_row[s] = 12'(r);
      if (!done) break;
      // position of the odd pixel that closed the block, halved
      oc   = (c == 0 ? ws : c) - 1;
      orow = (c == 0) ? (r == 0 ? hs - 1 : r - 1) : r;
      res.mip_pixel = avg;
      res.level     = LEVEL_W'(s + 1);
      res.col       = COORD_W'(oc >> 1);
      res.row       = COORD_W'(orow >> 1);
      res.last      = 1'b0;
      fresh = {fresh, res};
      cur = avg;  // the new pixel feeds the next level down
    end
    for (int i = 0; i < fresh.size(); i++) begin
      res = fresh[i];
      res.last = (i == fresh.size() - 1);
      pending_mips = {pending_mips, res};
    end
  endtask

  // register write as seen by the predictor: any write starts a new image
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    if (idx == REG_LOG2_WIDTH) log2_w_reg = val;
    else log2_h_reg = val;
    for (int s = 0; s <= MAX_LOG2; s++) begin
      stage_col[s] = '0;
      stage_row[s] = '0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // compares one accepted result beat with the oldest expectation
  task automatic check_mip_beat(input logic [TDATA_W-1:0] data, input logic last);
    result_t            want;
    logic [PIX_W-1:0]   got_pix;
    logic [LEVEL_W-1:0] got_level;
    logic [COORD_W-1:0] got_col, got_row;
    got_pix   = data[0 +: PIX_W];
    got_level = data[LEVEL_LSB +: LEVEL_W];
    got_col   = data[COL_LSB +: COORD_W];
    got_row   = data[ROW_LSB +: COORD_W];
    if (pending_mips.size() == 0) begin
      flag_mismatch($sformatf("beat with nothing expected: level %0d (%0d,%0d) pixel %h",
                              got_level, got_col, got_row, got_pix));
      return;
    end
    want = pending_mips.pop_front();
    if (got_pix !== want.mip_pixel)
      flag_mismatch($sformatf("level %0d (%0d,%0d): mip_pixel %h, expected %h",
                              want.level, want.col, want.row, got_pix, want.mip_pixel));
    if (got_level !== want.level)
      flag_mismatch($sformatf("level %0d, expected %0d", got_level, want.level));
    if (got_col !== want.col)
      flag_mismatch($sformatf("level %0d: col %0d, expected %0d", want.level, got_col,
                              want.col));
    if (got_row !== want.row)
      flag_mismatch($sformatf("level %0d: row %0d, expected %0d", want.level, got_row,
                              want.row));
    if (last !== want.last)
      flag_mismatch($sformatf("level %0d (%0d,%0d): tlast %b, expected %b", want.level,
                              want.col, want.row, last, want.last));
    mips_checked++;
    if (want.level > deepest_level) deepest_level = want.level;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall before each beat, checked on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else if (m_tready && m_tvalid) begin
      check_mip_beat(m_tdata, m_tlast);
      rx_wait = rx_calm ? 0 : $urandom_range(0, 9);
      if (rx_wait != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (rx_wait <= 1) m_tready <= 1'b1;
      else rx_wait--;
    end
  end

  // watchdog: a run of cycles with no beat on any port means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d results outstanding", $time, STALL_LIMIT,
               pending_mips.size());
      $display("mipmap_box_downsample test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers: all called at a rising edge
  // ---------------------------------------------------------------------------
  task automatic pick_pacing();
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
  endtask

  // offers one pixel after a random gap and waits for the beat to be taken
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    predict_mips(pix);
    pixels_sent++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // stops the input and waits for every expected beat; with settle it also lets
  // pixels that complete no block work through the cascade
  task automatic drain_results(input bit settle);
    s_tvalid <= 1'b0;
    while (pending_mips.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both exponents on back-to-back cycles; the block must be idle
  task automatic set_size(input int unsigned w, input int unsigned h);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_LOG2_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    apply_reg(REG_LOG2_WIDTH, CFG_W'(w));
    cfg_addr <= REG_LOG2_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    apply_reg(REG_LOG2_HEIGHT, CFG_W'(h));
    cfg_we <= 1'b0;
    size_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // 2x2 images: saturated, empty and mixed channels where carries and floors matter
  task automatic test_corner_pixels();
    set_size(1, 1);
    pick_pacing();
    repeat (4) send_pixel(32'hffff_ffff);
    repeat (4) send_pixel(32'h0000_0000);
    send_pixel(32'h807f_01ff);
    send_pixel(32'h7f80_00ff);
    send_pixel(32'h00ff_0100);
    send_pixel(32'hff00_0101);
    drain_results(1'b1);
  endtask

  // a zero exponent on either side gives no level, so pixels vanish
  task automatic test_no_levels();
    set_size(0, 2);
    pick_pacing();
    repeat (4) send_pixel(rand_pixel());
    drain_results(1'b1);
    set_size(2, 0);
    repeat (4) send_pixel(rand_pixel());
    drain_results(1'b1);
  endtask

  // whole images of several shapes; the first shape runs twice to wrap the counters,
  // with the sender holding off between the two until every result is in
  task automatic test_image_chain();
    int unsigned chain_w[6] = '{2, 3, 1, 3, 2, 1};
    int unsigned chain_h[6] = '{2, 3, 2, 1, 1, 2};
    for (int i = 0; i < 6; i++) begin
      set_size(chain_w[i], chain_h[i]);
      pick_pacing();
      send_random(1 << (chain_w[i] + chain_h[i]));
      if (i == 0) begin
        drain_results(1'b0);
        pick_pacing();
        send_random(1 << (chain_w[i] + chain_h[i]));
      end
      drain_results(1'b1);
    end
  endtask

  // a register write part way through an image must restart all level counters
  task automatic test_restart_mid_image();
    set_size(2, 2);
    pick_pacing();
    send_random(7);
    drain_results(1'b1);
    set_size(2, 2);
    send_random(16);
    drain_results(1'b1);
    set_size(3, 2);
    send_random(5);
    drain_results(1'b1);
    set_size(1, 2);
    send_random(8);
    drain_results(1'b1);
  endtask

  // exponents above the maximum clamp; a clamped height still gives results on a narrow image
  task automatic test_saturated_sizes();
    set_size(1, MAX_LOG2);
    pick_pacing();
    send_random(8);
    drain_results(1'b1);
    set_size(1, 15);
    pick_pacing();
    send_random(8);
    drain_results(1'b1);
    set_size(15, 1);
    pick_pacing();
    send_random(8);
    drain_results(1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    log2_w_reg = '0;
    log2_h_reg = '0;
    apply_reg(REG_LOG2_WIDTH, '0);

    test_corner_pixels();
    test_no_levels();
    test_image_chain();
    test_restart_mid_image();
    test_saturated_sizes();

    drain_results(1'b1);
    $display("covered %0d pixels under %0d size settings, exponents 0 to 15",
             pixels_sent, size_settings);
    $display("checked %0d mip beats down to level %0d, %0d mismatches",
             mips_checked, deepest_level, mismatches);
    if (mismatches == 0) begin
      $display("mipmap_box_downsample test passed");
    end else begin
      $display("mipmap_box_downsample test failed");
    end
    $finish;
  end

endmodule
